// File: sv/iee_pkg.sv
// Shared types and constants for the infix expression evaluator.
`timescale 1ns / 1ps
package iee_pkg;
  localparam int StackDepth = 32;
  localparam int ValueWidth = 32;
  localparam int PtrW = $clog2(StackDepth);
  localparam int CntW = $clog2(StackDepth + 1);

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DIVZERO  = 2'd1;
  localparam logic [1:0] ST_MISSING  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_POW   = 8'h5E;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // latch the incoming character
    logic digit;     // fold a digit into the pending number
    logic flush;     // push the pending number if one is active
    logic push_op;   // push the latched character
    logic pop_op;    // drop the top operator (matching paren)
    logic red_pop;   // pop operator and two operands into the ALU
    logic alu_go;    // start the ALU on the popped operands
    logic red_push;  // push the ALU result
    logic finish;    // capture the result and clear the expression state
  } iee_cmd_t;

  typedef struct packed {
    logic       op_empty;
    logic       top_is_lpar;
    logic       prec_ge;   // top precedence >= latched character precedence
    logic       alu_busy;
  } iee_sts_t;

  function automatic logic [1:0] prec_of(input logic [7:0] c);
    case (c)
      CH_PLUS, CH_MINUS: prec_of = 2'd1;
      CH_MUL, CH_DIV:    prec_of = 2'd2;
      CH_POW:            prec_of = 2'd3;
      default:           prec_of = 2'd0;
    endcase
  endfunction
endpackage

// File: sv/iee_alu.sv
// Arithmetic unit: add, subtract, multiply, and a bit-serial signed divider; other operators give zero.
`timescale 1ns / 1ps
module iee_alu import iee_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  go,
  input  logic [7:0]            op,
  input  logic [ValueWidth-1:0] a,
  input  logic [ValueWidth-1:0] b,
  output logic                  busy,
  output logic [ValueWidth-1:0] result,
  output logic                  div_zero
);
  localparam int BitW = $clog2(ValueWidth + 1);

  logic                  busy_r, busy_nxt;
  logic [BitW-1:0]       cnt_r, cnt_nxt;
  logic [ValueWidth-1:0] quo_r, quo_nxt;
  logic [ValueWidth-1:0] rem_r, rem_nxt;
  logic [ValueWidth-1:0] dvs_r, dvs_nxt;
  logic                  neg_r, neg_nxt;
  logic [ValueWidth-1:0] res_r, res_nxt;
  logic                  dz_r, dz_nxt;
  logic [ValueWidth-1:0] mag_a, mag_b;
  logic [ValueWidth:0]   trial;
  logic [ValueWidth-1:0] rem_sh;

  assign mag_a = a[ValueWidth-1] ? (~a + 1'b1) : a;
  assign mag_b = b[ValueWidth-1] ? (~b + 1'b1) : b;
  assign rem_sh = {rem_r[ValueWidth-2:0], quo_r[ValueWidth-1]};
  assign trial = {1'b0, rem_sh} - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    res_nxt  = res_r;
    dz_nxt   = 1'b0;
    if (go) begin
      case (op)
        CH_PLUS:  res_nxt = a + b;
        CH_MINUS: res_nxt = a - b;
        CH_MUL:   res_nxt = ValueWidth'(a * b);
        CH_DIV: begin
          if (b == '0) begin
            res_nxt = '0;
            dz_nxt  = 1'b1;
          end else begin
            busy_nxt = 1'b1;
            cnt_nxt  = BitW'(ValueWidth);
            quo_nxt  = mag_a;
            rem_nxt  = '0;
            dvs_nxt  = mag_b;
            neg_nxt  = a[ValueWidth-1] ^ b[ValueWidth-1];
          end
        end
        default:  res_nxt = '0;
      endcase
    end else if (busy_r) begin
      // One quotient bit per cycle, restoring division.
      if (!trial[ValueWidth]) begin
        rem_nxt = trial[ValueWidth-1:0];
        quo_nxt = {quo_r[ValueWidth-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[ValueWidth-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == BitW'(1)) begin
        busy_nxt = 1'b0;
        res_nxt  = neg_r ? (~quo_nxt + 1'b1) : quo_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      dz_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      dz_r   <= dz_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
    res_r <= res_nxt;
  end

  assign busy     = busy_r;
  assign result   = res_r;
  assign div_zero = dz_r;
endmodule

// File: sv/iee_datapath.sv
// Datapath: both stacks, the number builder, error flag and ALU.
`timescale 1ns / 1ps
module iee_datapath import iee_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  iee_cmd_t              cmd,
  input  logic [7:0]            char_in,
  output iee_sts_t              sts,
  output logic [31:0]           res_value,
  output logic [1:0]            res_status
);
  logic [7:0]            op_mem [StackDepth];
  logic [ValueWidth-1:0] val_mem [StackDepth];

  logic [CntW-1:0]       op_cnt_r, op_cnt_nxt;
  logic [CntW-1:0]       val_cnt_r, val_cnt_nxt;
  logic [ValueWidth-1:0] num_r, num_nxt;
  logic                  num_act_r, num_act_nxt;
  logic [1:0]            err_r, err_nxt;
  logic [7:0]            ch_r;
  logic [7:0]            op_top_r;     // copy of the top operator
  logic [7:0]            alu_op_r;
  logic [ValueWidth-1:0] opa_r, opb_r;
  logic [31:0]           res_value_r;
  logic [1:0]            res_status_r;
  logic [ValueWidth-1:0] top_val, sec_val;
  logic [ValueWidth-1:0] alu_res;
  logic                  alu_busy, alu_dz;
  logic [1:0]            err_tmp;
  logic                  op_we, val_we;
  logic [PtrW-1:0]       op_wa, val_wa;
  logic [7:0]            op_wd;
  logic [ValueWidth-1:0] val_wd;
  logic [7:0]            op_below;

  // Top two entries are read by the reduction; the stack is small enough
  // to keep in registers with fixed-address top reads via the count.
  assign top_val  = val_mem[PtrW'(val_cnt_r - 1'b1)];
  assign sec_val  = val_mem[PtrW'(val_cnt_r - 2'd2)];
  assign op_below = op_mem[PtrW'(op_cnt_r - 2'd2)];

  iee_alu u_alu (
    .clk(clk), .rst_n(rst_n), .go(cmd.alu_go), .op(alu_op_r),
    .a(opa_r), .b(opb_r), .busy(alu_busy), .result(alu_res), .div_zero(alu_dz)
  );

  always_comb begin
    op_cnt_nxt  = op_cnt_r;
    val_cnt_nxt = val_cnt_r;
    num_nxt     = num_r;
    num_act_nxt = num_act_r;
    err_tmp     = err_r;
    op_we  = 1'b0; op_wa = PtrW'(op_cnt_r);  op_wd = ch_r;
    val_we = 1'b0; val_wa = PtrW'(val_cnt_r); val_wd = num_r;
    if (alu_dz && err_tmp == ST_OK) err_tmp = ST_DIVZERO;
    if (cmd.digit) begin
      num_nxt = ValueWidth'(num_r * ValueWidth'(10))
                + ValueWidth'(char_in - CH_ZERO);
      num_act_nxt = 1'b1;
    end
    if (cmd.flush && num_act_r) begin
      num_nxt = '0;
      num_act_nxt = 1'b0;
      if (val_cnt_r == CntW'(StackDepth)) begin
        if (err_tmp == ST_OK) err_tmp = ST_OVERFLOW;
      end else begin
        val_we = 1'b1;
        val_cnt_nxt = val_cnt_r + 1'b1;
      end
    end
    if (cmd.push_op) begin
      if (op_cnt_r == CntW'(StackDepth)) begin
        if (err_tmp == ST_OK) err_tmp = ST_OVERFLOW;
      end else begin
        op_we = 1'b1;
        op_cnt_nxt = op_cnt_r + 1'b1;
      end
    end
    if (cmd.pop_op) op_cnt_nxt = op_cnt_r - 1'b1;
    if (cmd.red_pop) begin
      op_cnt_nxt = op_cnt_r - 1'b1;
      if (val_cnt_r < CntW'(2)) begin
        if (err_tmp == ST_OK) err_tmp = ST_MISSING;
        val_cnt_nxt = '0;
      end else begin
        val_cnt_nxt = val_cnt_r - CntW'(2);
      end
    end
    if (cmd.red_push) begin
      if (val_cnt_r == CntW'(StackDepth)) begin
        if (err_tmp == ST_OK) err_tmp = ST_OVERFLOW;
      end else begin
        val_we = 1'b1;
        val_wd = alu_res;
        val_cnt_nxt = val_cnt_r + 1'b1;
      end
    end
    err_nxt = err_tmp;
    if (cmd.finish) begin
      if (val_cnt_r == '0 && err_tmp == ST_OK) err_nxt = ST_MISSING;
      op_cnt_nxt  = '0;
      val_cnt_nxt = '0;
      num_nxt     = '0;
      num_act_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_cnt_r  <= '0;
      val_cnt_r <= '0;
      num_r     <= '0;
      num_act_r <= 1'b0;
      err_r     <= ST_OK;
    end else begin
      op_cnt_r  <= op_cnt_nxt;
      val_cnt_r <= val_cnt_nxt;
      num_r     <= num_nxt;
      num_act_r <= num_act_nxt;
      err_r     <= cmd.finish ? ST_OK : err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (op_we) op_mem[op_wa] <= op_wd;
    if (val_we) val_mem[val_wa] <= val_wd;
    if (cmd.load) ch_r <= char_in;
    if (op_we) op_top_r <= op_wd;
    else if (cmd.pop_op || cmd.red_pop) op_top_r <= op_below;
    if (cmd.red_pop) begin
      alu_op_r <= op_top_r;
      opb_r <= (val_cnt_r >= CntW'(1)) ? top_val : '0;
      opa_r <= (val_cnt_r >= CntW'(2)) ? sec_val : '0;
    end
    if (cmd.finish) begin
      res_value_r  <= (val_cnt_r == '0) ? 32'd0 : 32'(signed'(top_val));
      res_status_r <= err_nxt;
    end
  end

  assign sts.op_empty    = (op_cnt_r == '0);
  assign sts.top_is_lpar = (op_top_r == CH_LPAR);
  assign sts.prec_ge     = (prec_of(op_top_r) >= prec_of(ch_r));
  assign sts.alu_busy    = alu_busy;
  assign res_value  = res_value_r;
  assign res_status = res_status_r;
endmodule

// File: sv/iee_ctrl.sv
// Controller state machine sequencing one character through the stacks.
`timescale 1ns / 1ps
module iee_ctrl import iee_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_char,
  input  logic       in_last,
  output logic       in_ready,
  input  iee_sts_t   sts,
  output iee_cmd_t   cmd,
  output logic       out_valid,
  input  logic       out_ready
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLASS  = 4'd1;
  localparam logic [3:0] S_RLOOP  = 4'd2;  // ')' reduction loop
  localparam logic [3:0] S_OLOOP  = 4'd3;  // operator precedence loop
  localparam logic [3:0] S_ELOOP  = 4'd4;  // end-of-expression loop
  localparam logic [3:0] S_ALU    = 4'd5;
  localparam logic [3:0] S_WAIT   = 4'd6;
  localparam logic [3:0] S_PUSH   = 4'd7;
  localparam logic [3:0] S_LAST   = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic [3:0] ret_r, ret_nxt;
  logic       last_r, last_nxt;
  logic [7:0] ch_r, ch_nxt;
  logic       ov_r, ov_nxt;
  logic       acc;

  // The result register is only overwritten in S_FIN, which waits until a waiting result
  // is taken; the next expression is still accepted and reduced meanwhile.
  assign in_ready = (state_r == S_IDLE);
  assign acc = in_valid && in_ready;
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    last_nxt  = last_r;
    ch_nxt    = ch_r;
    ov_nxt    = ov_r;
    cmd       = '0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          cmd.load = 1'b1;
          ch_nxt   = in_char;
          last_nxt = in_last;
          if (in_char >= CH_ZERO && in_char <= CH_NINE) begin
            cmd.digit = 1'b1;
            state_nxt = in_last ? S_LAST : S_IDLE;
          end else begin
            cmd.flush = 1'b1;
            state_nxt = S_CLASS;
          end
        end
      end
      S_CLASS: begin
        if (ch_r == CH_SPACE) begin
          state_nxt = S_LAST;
        end else if (ch_r == CH_LPAR) begin
          cmd.push_op = 1'b1;
          state_nxt = S_LAST;
        end else if (ch_r == CH_RPAR) begin
          state_nxt = S_RLOOP;
        end else begin
          state_nxt = S_OLOOP;
        end
      end
      S_RLOOP: begin
        if (sts.op_empty) begin
          state_nxt = S_LAST;
        end else if (sts.top_is_lpar) begin
          cmd.pop_op = 1'b1;
          state_nxt = S_LAST;
        end else begin
          cmd.red_pop = 1'b1;
          ret_nxt = S_RLOOP;
          state_nxt = S_ALU;
        end
      end
      S_OLOOP: begin
        if (!sts.op_empty && sts.prec_ge) begin
          cmd.red_pop = 1'b1;
          ret_nxt = S_OLOOP;
          state_nxt = S_ALU;
        end else begin
          cmd.push_op = 1'b1;
          state_nxt = S_LAST;
        end
      end
      S_ALU: begin
        cmd.alu_go = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (!sts.alu_busy) state_nxt = S_PUSH;
      end
      S_PUSH: begin
        cmd.red_push = 1'b1;
        state_nxt = ret_r;
      end
      S_LAST: begin
        if (last_r) begin
          cmd.flush = 1'b1;
          state_nxt = S_ELOOP;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_ELOOP: begin
        if (sts.op_empty) begin
          state_nxt = S_FIN;
        end else begin
          cmd.red_pop = 1'b1;
          ret_nxt = S_ELOOP;
          state_nxt = S_ALU;
        end
      end
      S_FIN: begin
        if (!ov_r) begin
          cmd.finish = 1'b1;
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      last_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      last_r  <= last_nxt;
      ov_r    <= ov_nxt;
    end
    ch_r <= ch_nxt;
  end
endmodule

// File: sv/infix_expression_evaluator.sv
// Top level of the infix expression evaluator.
// Sequencing: a digit is folded into the pending number as it is accepted; other characters
// go through S_CLASS and the stack loops, each reduction through S_ALU, S_WAIT and S_PUSH.
// After the last reduction of the end character, S_ELOOP and then S_FIN register the result.
// Throughput: one character at a time; the stack reduction loop sets the rate.
// Reset: synchronous active-low rst_n empties both stacks and clears errors.
`timescale 1ns / 1ps
module infix_expression_evaluator import iee_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,   // end_of_expr
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [31:0] value, [33:32] status, zero fill
);
  iee_cmd_t    cmd;
  iee_sts_t    sts;
  logic [31:0] res_value;
  logic [1:0]  res_status;

  iee_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_char(in_tdata),
    .in_last(in_tlast), .in_ready(in_tready), .sts(sts), .cmd(cmd),
    .out_valid(out_tvalid), .out_ready(out_tready)
  );

  iee_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .char_in(in_tdata), .sts(sts),
    .res_value(res_value), .res_status(res_status)
  );

  assign out_tdata = {6'd0, res_status, res_value};
endmodule

// File: sim/iee_checker.sv
// Checker for the infix expression evaluator: predicts results and compares them.
`timescale 1ns / 1ps
module iee_checker import iee_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  output int          fail_count,
  output int          pending_results
);
  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
  } eval_result_t;

  eval_result_t results_q[$];
  logic [7:0]   op_stk[StackDepth];
  logic [31:0]  val_stk[StackDepth];
  int           op_cnt;
  int           val_cnt;
  logic [31:0]  number;
  logic         number_on;
  logic [1:0]   first_err;

  assign pending_results = results_q.size();

  function automatic void clear_expr();
    op_cnt = 0;
    val_cnt = 0;
    number = '0;
    number_on = 1'b0;
    first_err = ST_OK;
  endfunction

  function automatic void note_err(logic [1:0] code);
    if (first_err == ST_OK) first_err = code;
  endfunction

  function automatic void push_val(logic [31:0] v);
    if (val_cnt >= StackDepth) note_err(ST_OVERFLOW);
    else begin
      val_stk[val_cnt] = v;
      val_cnt++;
    end
  endfunction

  function automatic logic [31:0] pop_val();
    if (val_cnt == 0) begin
      note_err(ST_MISSING);
      return '0;
    end
    val_cnt--;
    return val_stk[val_cnt];
  endfunction

  function automatic logic [1:0] rank(logic [7:0] c);
    if (c == CH_PLUS || c == CH_MINUS) return 2'd1;
    if (c == CH_MUL || c == CH_DIV) return 2'd2;
    if (c == CH_POW) return 2'd3;
    return 2'd0;
  endfunction

  function automatic logic [31:0] apply_op(logic [31:0] a, logic [31:0] b, logic [7:0] op);
    logic [31:0] ma, mb, q;
    case (op)
      CH_PLUS:  return a + b;
      CH_MINUS: return a - b;
      CH_MUL:   return a * b;
      CH_DIV: begin
        if (b == 0) begin
          note_err(ST_DIVZERO);
          return '0;
        end
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        return (a[31] ^ b[31]) ? -q : q;
      end
      default:  return '0;
    endcase
  endfunction

  function automatic void reduce_top();
    logic [7:0]  op;
    logic [31:0] a, b;
    if (op_cnt == 0) return;
    op_cnt--;
    op = op_stk[op_cnt];
    b = pop_val();
    a = pop_val();
    push_val(apply_op(a, b, op));
  endfunction

  function automatic void flush_number();
    if (number_on) begin
      push_val(number);
      number = '0;
      number_on = 1'b0;
    end
  endfunction

  function automatic void eval_char(logic [7:0] c, logic last);
    eval_result_t r;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      number = number * 32'd10 + 32'(c - CH_ZERO);
      number_on = 1'b1;
    end else begin
      flush_number();
      if (c == CH_SPACE) begin
      end else if (c == CH_LPAR) begin
        if (op_cnt >= StackDepth) note_err(ST_OVERFLOW);
        else begin
          op_stk[op_cnt] = c;
          op_cnt++;
        end
      end else if (c == CH_RPAR) begin
        while (op_cnt > 0 && op_stk[op_cnt-1] != CH_LPAR) reduce_top();
        if (op_cnt > 0) op_cnt--;
      end else begin
        while (op_cnt > 0 && rank(op_stk[op_cnt-1]) >= rank(c)) reduce_top();
        if (op_cnt >= StackDepth) note_err(ST_OVERFLOW);
        else begin
          op_stk[op_cnt] = c;
          op_cnt++;
        end
      end
    end
    if (!last) return;
    flush_number();
    while (op_cnt > 0) reduce_top();
    if (val_cnt == 0) begin
      note_err(ST_MISSING);
      r.value = '0;
    end else begin
      r.value = val_stk[val_cnt-1];
    end
    r.status = first_err;
    results_q.push_back(r);
    clear_expr();
  endfunction

  always @(posedge clk) begin
    eval_result_t want;
    if (!rst_n) begin
      clear_expr();
      results_q.delete();
      fail_count <= 0;
    end else begin
      if (in_tvalid && in_tready) eval_char(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (results_q.size() == 0) begin
          $error("result with no expression pending: value %0d status %0d",
                 $signed(out_tdata[31:0]), out_tdata[33:32]);
          fail_count <= fail_count + 1;
        end else begin
          want = results_q.pop_front();
          if (out_tdata[31:0] !== want.value) begin
            $error("value: expected %0d, got %0d", $signed(want.value),
                   $signed(out_tdata[31:0]));
            fail_count <= fail_count + 1;
          end else if (out_tdata[33:32] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tdata[33:32]);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// File: sim/tb_infix_expression_evaluator.sv
// Testbench top: drives expressions into the evaluator and reports the verdict.
`timescale 1ns / 1ps
module tb_infix_expression_evaluator import iee_pkg::*;;
  localparam int CycleLimit = 2_000_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  int          fail_count;
  int          pending_results;
  int          cycles = 0;

  logic [7:0] expr_chars[$];
  logic       expr_lasts[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  infix_expression_evaluator u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  iee_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending_results(pending_results)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver stalls at random, with stretches of full readiness.
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (cycles % 2000 < 300) out_tready <= 1'b1;
    else out_tready <= (gap_len() == 0);
  end

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      expr_chars.push_back(s[i]);
      expr_lasts.push_back(i == s.len() - 1);
    end
  endfunction

  function automatic logic [7:0] rand_op();
    case ($urandom_range(0, 3))
      0: return CH_PLUS;
      1: return CH_MINUS;
      2: return CH_MUL;
      default: return CH_DIV;
    endcase
  endfunction

  function automatic string rand_number();
    string s;
    int n;
    s = "";
    n = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 3);
    for (int i = 0; i < n; i++) s = {s, string'(8'(CH_ZERO + $urandom_range(0, 9)))};
    return s;
  endfunction

  // Well-formed expression with random content, depth bounded.
  function automatic string rand_expr(int depth);
    string s;
    int terms;
    s = "";
    terms = $urandom_range(1, 4);
    for (int i = 0; i < terms; i++) begin
      if (i > 0) begin
        if ($urandom_range(0, 3) == 0) s = {s, " "};
        s = {s, string'(rand_op())};
      end
      if (depth > 0 && $urandom_range(0, 3) == 0) s = {s, "(", rand_expr(depth - 1), ")"};
      else s = {s, rand_number()};
    end
    return s;
  endfunction

  function automatic void add_noise();
    int n;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      expr_chars.push_back(8'($urandom_range(0, 255)));
      expr_lasts.push_back(i == n - 1);
    end
  endfunction

  task automatic send_all();
    while (expr_chars.size() > 0) begin
      in_tvalid <= 1'b1;
      in_tdata <= expr_chars.pop_front();
      in_tlast <= expr_lasts.pop_front();
      do @(posedge clk); while (!in_tready);
      if (expr_chars.size() == 0 || gap_len() != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end
    end
  endtask

  initial begin
    string deep;
    int sent;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: operators, errors, wrap, spaces, parens, overflow.
    add_text("1+2*3-4/2");
    add_text("(1+2)*3");
    add_text("7/0");
    add_text("+");
    add_text(" ");
    add_text("2^3");
    add_text("1 2");
    add_text("4294967295+1");
    add_text("99999999999");
    add_text("2147483648/-1");
    add_text("0-7/2");
    add_text("1+2)*3");
    add_text("(((5");
    add_text("3#4");
    deep = "";
    for (int i = 0; i < 34; i++) deep = {deep, "("};
    add_text({deep, "1"});
    deep = "";
    for (int i = 0; i < 34; i++) deep = {deep, "1 "};
    add_text(deep);
    expr_chars.push_back(8'hFF); expr_lasts.push_back(1'b1);
    expr_chars.push_back(8'h00); expr_lasts.push_back(1'b1);
    send_all();
    sent = 0;
    while (sent < 1050) begin
      if ($urandom_range(0, 9) < 8) add_text(rand_expr(2));
      else add_noise();
      sent += expr_chars.size();
      send_all();
    end
    while (pending_results != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
